// ----- hdl/gslc_pkg.sv -----
// shared types and constants for the glyph slot lfu cache
package gslc_pkg;

  // storage geometry
  localparam int SLOT_COUNT = 256;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int INDEX_BITS = 14;
  localparam int COUNT_BITS = 15;

  // fixed field widths of the beats
  localparam int GLYPH_FIELD_BITS = 14;
  localparam int SLOT_FIELD_BITS  = 8;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t  COUNT_MAX = '1;
  localparam cnt_t  COUNT_ONE = cnt_t'(1);
  localparam slot_t SLOT_LAST = slot_t'(SLOT_COUNT - 1);

  // action codes
  localparam logic ACT_ACCESS  = 1'b0;
  localparam logic ACT_END_RUN = 1'b1;

  typedef struct packed {
    logic                        action;
    logic [GLYPH_FIELD_BITS-1:0] glyph_index;
    logic                        glyph_available;
  } in_beat_t;

  typedef struct packed {
    logic [SLOT_FIELD_BITS-1:0]  slot;
    logic                        hit;
    logic                        load_error;
    logic                        evicted;
    logic [GLYPH_FIELD_BITS-1:0] evicted_index;
  } out_beat_t;

  // one slot of the table
  typedef struct packed {
    idx_t glyph;
    cnt_t count;
    logic pinned;
  } entry_t;

  // request from the controller to the slot memory
  typedef struct packed {
    logic   rd_en;
    slot_t  rd_addr;
    logic   wr_en;
    slot_t  wr_addr;
    entry_t wr_data;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_WRITE,
    ST_DONE
  } ctrl_state_t;

endpackage

// ----- hdl/glyph_slot_lfu_cache_core.sv -----
// top level of the glyph slot cache with least-frequently-used replacement
//
//  channel  ports                          beat
//  -------  -----------------------------  ------------------------------------------
//  in       in_valid  in_ready  in_data    action, glyph_index, glyph_available
//  out      out_valid out_ready out_data   slot, hit, load_error, evicted, evicted_index
//
// an access beat walks the slot memory one slot per cycle, a pace set by the
// single read port of the slot memory: a hit on slot k ends the walk there,
// a miss walks all SLOT_COUNT slots (256)
// an end-of-run beat walks every slot, rewriting each pinned slot
// reset clears the per-slot valid bits at once, so no clearing pass is needed
// a result waits in the output register; a new beat is taken meanwhile, and a
// finished result only stalls while the output register is still full
module glyph_slot_lfu_cache_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gslc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gslc_pkg::out_beat_t out_data
);

  gslc_pkg::ram_req_t  ram_req;
  gslc_pkg::entry_t    rd_data;
  logic                res_valid;
  gslc_pkg::out_beat_t res_data;
  logic                out_free;

  logic                out_valid_r, out_valid_nxt;
  gslc_pkg::out_beat_t out_data_r, out_data_nxt;

  // output register frees when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  // sequencer: lookup scan, victim pick, pin clear sweep, writeback
  gslc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .rd_data   (rd_data),
    .ram_req   (ram_req),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (out_free)
  );

  // slot table: glyph, use count and pinned flag per slot
  gslc_slot_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no table write while waiting for a new beat
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !ram_req.wr_en)
    else $error("slot table written while idle");

  // read and write never target the same slot in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
    else $error("read and write collide on one slot");

  // a finished result lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_free) |=> out_valid)
    else $error("result lost before output register");

  // eviction only comes with a load
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.evicted && (out_data.hit || out_data.load_error)))
    else $error("eviction reported without a load");

endmodule

// ----- hdl/gslc_slot_ram.sv -----
// slot table memory with one read and one write port, valid bit per slot
module gslc_slot_ram (
  input  logic               clk,
  input  logic               rst_n,
  input  gslc_pkg::ram_req_t req,
  output gslc_pkg::entry_t   rd_data
);

  gslc_pkg::entry_t               mem_r [gslc_pkg::SLOT_COUNT];
  gslc_pkg::entry_t               rdata_r;
  logic [gslc_pkg::SLOT_COUNT-1:0] vld_r;
  logic                           rvld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[req.rd_addr];
    end
  end

  // never-written slots read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

// ----- hdl/gslc_ctrl.sv -----
// scan sequencer: lookup, victim choice, pin clearing and writeback
module gslc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  gslc_pkg::in_beat_t  in_data,
  output logic                in_ready,
  input  gslc_pkg::entry_t    rd_data,
  output gslc_pkg::ram_req_t  ram_req,
  output logic                res_valid,
  output gslc_pkg::out_beat_t res_data,
  input  logic                res_take
);

  gslc_pkg::ctrl_state_t state_r, state_nxt;

  logic                act_r, act_nxt;
  gslc_pkg::idx_t      idx_r, idx_nxt;
  logic                avail_r, avail_nxt;
  gslc_pkg::slot_t     iss_r, iss_nxt;
  logic                iss_live_r, iss_live_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  gslc_pkg::slot_t     chk_addr_r, chk_addr_nxt;
  logic                hit_fnd_r, hit_fnd_nxt;
  gslc_pkg::slot_t     hit_slot_r, hit_slot_nxt;
  gslc_pkg::cnt_t      hit_cnt_r, hit_cnt_nxt;
  logic                empty_fnd_r, empty_fnd_nxt;
  gslc_pkg::slot_t     empty_slot_r, empty_slot_nxt;
  gslc_pkg::cnt_t      least_r, least_nxt;
  gslc_pkg::slot_t     best_r, best_nxt;
  gslc_pkg::idx_t      best_glyph_r, best_glyph_nxt;
  gslc_pkg::out_beat_t res_r, res_nxt;

  logic            accept;
  logic            match;
  logic            chk_last;
  logic            scanning;
  gslc_pkg::slot_t victim;
  gslc_pkg::slot_t wb_slot;
  gslc_pkg::cnt_t  wb_cnt;

  assign accept   = (state_r == gslc_pkg::ST_IDLE) && in_valid;
  assign match    = chk_vld_r && (rd_data.count != '0) && (rd_data.glyph == idx_r);
  assign chk_last = chk_vld_r && (chk_addr_r == gslc_pkg::SLOT_LAST);
  assign scanning = (state_r == gslc_pkg::ST_SCAN) || (state_r == gslc_pkg::ST_CLEAR);
  assign victim   = empty_fnd_r ? empty_slot_r : best_r;
  assign wb_slot  = hit_fnd_r ? hit_slot_r : victim;
  assign wb_cnt   = (hit_cnt_r == gslc_pkg::COUNT_MAX) ? hit_cnt_r
                                                       : gslc_pkg::cnt_t'(hit_cnt_r + 1'b1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gslc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.action == gslc_pkg::ACT_END_RUN) ? gslc_pkg::ST_CLEAR
                                                                : gslc_pkg::ST_SCAN;
        end
      end
      gslc_pkg::ST_SCAN: begin
        if (match || chk_last) begin
          state_nxt = gslc_pkg::ST_WRITE;
        end
      end
      gslc_pkg::ST_CLEAR: begin
        if (chk_last) begin
          state_nxt = gslc_pkg::ST_WRITE;
        end
      end
      gslc_pkg::ST_WRITE: begin
        state_nxt = gslc_pkg::ST_DONE;
      end
      gslc_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = gslc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gslc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = (state_r == gslc_pkg::ST_IDLE);
    res_valid       = (state_r == gslc_pkg::ST_DONE);
    ram_req         = '0;
    ram_req.rd_en   = scanning && iss_live_r;
    ram_req.rd_addr = iss_r;
    unique case (state_r)
      gslc_pkg::ST_CLEAR: begin
        ram_req.wr_en          = chk_vld_r && rd_data.pinned;
        ram_req.wr_addr        = chk_addr_r;
        ram_req.wr_data        = rd_data;
        ram_req.wr_data.pinned = 1'b0;
      end
      gslc_pkg::ST_WRITE: begin
        ram_req.wr_en          = !act_r && (hit_fnd_r || avail_r);
        ram_req.wr_addr        = wb_slot;
        ram_req.wr_data.glyph  = idx_r;
        ram_req.wr_data.count  = hit_fnd_r ? wb_cnt : gslc_pkg::COUNT_ONE;
        ram_req.wr_data.pinned = 1'b1;
      end
      gslc_pkg::ST_IDLE, gslc_pkg::ST_SCAN, gslc_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    act_nxt        = act_r;
    idx_nxt        = idx_r;
    avail_nxt      = avail_r;
    iss_nxt        = iss_r;
    iss_live_nxt   = iss_live_r;
    chk_vld_nxt    = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    hit_fnd_nxt    = hit_fnd_r;
    hit_slot_nxt   = hit_slot_r;
    hit_cnt_nxt    = hit_cnt_r;
    empty_fnd_nxt  = empty_fnd_r;
    empty_slot_nxt = empty_slot_r;
    least_nxt      = least_r;
    best_nxt       = best_r;
    best_glyph_nxt = best_glyph_r;
    res_nxt        = res_r;

    if (accept) begin
      act_nxt       = in_data.action;
      idx_nxt       = gslc_pkg::idx_t'(in_data.glyph_index);
      avail_nxt     = in_data.glyph_available;
      iss_nxt       = '0;
      iss_live_nxt  = 1'b1;
      hit_fnd_nxt   = 1'b0;
      empty_fnd_nxt = 1'b0;
      least_nxt     = gslc_pkg::COUNT_MAX;
      best_nxt      = '0;
    end

    if (scanning) begin
      chk_vld_nxt  = iss_live_r;
      chk_addr_nxt = iss_r;
      if (iss_live_r) begin
        iss_nxt      = gslc_pkg::slot_t'(iss_r + 1'b1);
        iss_live_nxt = (iss_r != gslc_pkg::SLOT_LAST);
      end
    end

    if ((state_r == gslc_pkg::ST_SCAN) && chk_vld_r) begin
      if (match) begin
        hit_fnd_nxt  = 1'b1;
        hit_slot_nxt = chk_addr_r;
        hit_cnt_nxt  = rd_data.count;
      end
      if ((rd_data.count == '0) && !empty_fnd_r) begin
        empty_fnd_nxt  = 1'b1;
        empty_slot_nxt = chk_addr_r;
      end
      // least count among unpinned, later slot wins a tie; slot 0 is the fallback
      if (!rd_data.pinned && (rd_data.count <= least_r)) begin
        least_nxt      = rd_data.count;
        best_nxt       = chk_addr_r;
        best_glyph_nxt = rd_data.glyph;
      end else if (chk_addr_r == '0) begin
        best_glyph_nxt = rd_data.glyph;
      end
    end

    if (state_r == gslc_pkg::ST_WRITE) begin
      res_nxt = '0;
      if (!act_r) begin
        if (hit_fnd_r) begin
          res_nxt.slot = gslc_pkg::SLOT_FIELD_BITS'(hit_slot_r);
          res_nxt.hit  = 1'b1;
        end else if (!avail_r) begin
          res_nxt.load_error = 1'b1;
        end else begin
          res_nxt.slot    = gslc_pkg::SLOT_FIELD_BITS'(victim);
          res_nxt.evicted = !empty_fnd_r;
          res_nxt.evicted_index = empty_fnd_r ? '0
                                  : gslc_pkg::GLYPH_FIELD_BITS'(best_glyph_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gslc_pkg::ST_IDLE;
      iss_live_r <= 1'b0;
      chk_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_live_r <= iss_live_nxt;
      chk_vld_r  <= chk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    idx_r        <= idx_nxt;
    avail_r      <= avail_nxt;
    iss_r        <= iss_nxt;
    chk_addr_r   <= chk_addr_nxt;
    hit_fnd_r    <= hit_fnd_nxt;
    hit_slot_r   <= hit_slot_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    empty_fnd_r  <= empty_fnd_nxt;
    empty_slot_r <= empty_slot_nxt;
    least_r      <= least_nxt;
    best_r       <= best_nxt;
    best_glyph_r <= best_glyph_nxt;
    res_r        <= res_nxt;
  end

  assign res_data = res_r;

endmodule
